// ===== sv/ubqp_pkg.sv =====
// ----------------------------------------------------------------------------
// ubqp_pkg
// Shared types and constants for the buffered serial queue pair.
// ----------------------------------------------------------------------------
`default_nettype none

package ubqp_pkg;

	localparam int unsigned BYTE_W         = 8;
	localparam int unsigned CFG_W          = 9;
	localparam int unsigned CFG_IDX_W      = 2;
	localparam int unsigned SIZE_RESET     = 256;
	localparam int unsigned RX_DEPTH_DEF   = 256;
	localparam int unsigned TX_DEPTH_DEF   = 256;
	localparam int unsigned CNT_OUT_W      = 9;
	localparam int unsigned IN_TDATA_W     = 24;
	localparam int unsigned OUT_TDATA_W    = 32;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_RX_SIZE     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TX_SIZE     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_NONBLOCKING = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RUNNING     = 2'd3;

	typedef enum logic [2:0] {
		OP_LINE_IN  = 3'd0,
		OP_TX_READY = 3'd1,
		OP_PUT      = 3'd2,
		OP_GET      = 3'd3,
		OP_PEEK     = 3'd4,
		OP_UNGET    = 3'd5
	} op_t;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_NOT_RUN    = 3'd1,
		ST_EMPTY      = 3'd2,
		ST_RETRY      = 3'd3,
		ST_DROPPED    = 3'd4,
		ST_BAD_OFFSET = 3'd5
	} status_t;

	typedef struct packed {
		logic push;
		logic pop;
	} ring_cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} ring_flag_t;

endpackage

`default_nettype wire

// ===== sv/ubqp_ram.sv =====
// ----------------------------------------------------------------------------
// ubqp_ram
// Byte store for one ring: one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ubqp_ram
	import ubqp_pkg::*;
#(
	parameter int unsigned DEPTH = RX_DEPTH_DEF,
	localparam int unsigned AW   = $clog2(DEPTH)
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [AW-1:0]     waddr,
	input  wire logic [BYTE_W-1:0] wdata,
	input  wire logic              re,
	input  wire logic [AW-1:0]     raddr,
	output logic      [BYTE_W-1:0] rdata
);

	logic [BYTE_W-1:0] mem [DEPTH];
	logic [BYTE_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read data holds until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== sv/ubqp_ring.sv =====
// ----------------------------------------------------------------------------
// ubqp_ring
// Pointer, flag and size control for one ring; reports the fill count.
// ----------------------------------------------------------------------------
`default_nettype none

module ubqp_ring
	import ubqp_pkg::*;
#(
	parameter int unsigned DEPTH = RX_DEPTH_DEF,
	localparam int unsigned AW   = $clog2(DEPTH),
	localparam int unsigned SW   = $clog2(DEPTH + 1)
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             size_we,
	input  wire logic [CFG_W-1:0] size_wdata,
	input  wire ring_cmd_t        cmd,
	output logic      [AW-1:0]    head,
	output logic      [AW-1:0]    tail,
	output ring_flag_t            flags,
	output logic      [SW-1:0]    size,
	output logic      [SW-1:0]    fill
);

	localparam int unsigned SIZE_RST = (DEPTH < SIZE_RESET) ? DEPTH : SIZE_RESET;

	logic [AW-1:0] head_q, tail_q;
	logic          full_q, empty_q;
	logic [SW-1:0] size_q;
	logic [SW-1:0] size_d;
	logic [SW-1:0] head_inc, tail_inc;
	logic [AW-1:0] head_adv, tail_adv;

	// saturate the written size to 1..DEPTH
	always_comb begin
		if (size_wdata == '0) begin
			size_d = SW'(1);
		end else if (32'(size_wdata) > DEPTH) begin
			size_d = SW'(DEPTH);
		end else begin
			size_d = SW'(size_wdata);
		end
	end

	assign head_inc = SW'(head_q) + SW'(1);
	assign tail_inc = SW'(tail_q) + SW'(1);
	assign head_adv = (head_inc >= size_q) ? '0 : head_inc[AW-1:0];
	assign tail_adv = (tail_inc >= size_q) ? '0 : tail_inc[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			full_q  <= 1'b0;
			empty_q <= 1'b1;
			size_q  <= SW'(SIZE_RST);
		end else if (size_we) begin
			size_q  <= size_d;
			head_q  <= '0;
			tail_q  <= '0;
			full_q  <= 1'b0;
			empty_q <= 1'b1;
		end else if (cmd.push) begin
			head_q  <= head_adv;
			empty_q <= 1'b0;
			full_q  <= (head_adv == tail_q);
		end else if (cmd.pop) begin
			tail_q  <= tail_adv;
			full_q  <= 1'b0;
			empty_q <= (head_q == tail_adv);
		end
	end

	always_comb begin
		if (full_q) begin
			fill = size_q;
		end else if (head_q >= tail_q) begin
			fill = SW'(head_q) - SW'(tail_q);
		end else begin
			fill = SW'(head_q) + size_q - SW'(tail_q);
		end
	end

	assign head        = head_q;
	assign tail        = tail_q;
	assign flags.full  = full_q;
	assign flags.empty = empty_q;
	assign size        = size_q;

endmodule

`default_nettype wire

// ===== sv/uart_buffered_queue_pair_core.sv =====
// ----------------------------------------------------------------------------
// uart_buffered_queue_pair_core
// Receive and transmit byte rings between a serial line and a host.
// ----------------------------------------------------------------------------
// One input channel (s_axis) carries events: line byte in, transmitter
// ready, host put, get, peek and unget. Each event gives exactly one result
// on m_axis: byte read or sent, status, receive count, transmit space, RTS
// and the transmit-pending request. Configuration is a plain write port for
// the ring sizes, the nonblocking mode and the running enable.
// An event accepted at a clock edge shows its result in the output register
// after that edge. Throughput is one event per cycle while the receiver
// does not stall; each event makes at most one memory access, and read
// data is registered. When the receiver stalls, the result holds and
// s_axis_tready drops until the result is taken; a new event can enter in that same cycle.
// Reset empties both rings (pointers to zero, empty set), sets both sizes to
// 256 or the depth if smaller, clears nonblocking and running. The byte
// stores are not cleared; there is no clearing pass. Writing a size empties
// that ring.
// ----------------------------------------------------------------------------
`default_nettype none

module uart_buffered_queue_pair_core
	import ubqp_pkg::*;
#(
	parameter int unsigned RX_DEPTH = RX_DEPTH_DEF,
	parameter int unsigned TX_DEPTH = TX_DEPTH_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_we,
	input  wire logic [CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [CFG_W-1:0]       cfg_wdata,
	input  wire logic                   s_axis_tvalid,
	output logic                        s_axis_tready,
	// operation[2:0], byte_in[10:3], peek_offset[18:11], cts_high[19], zero
	input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
	output logic                        m_axis_tvalid,
	input  wire logic                   m_axis_tready,
	// byte_out[7:0], byte_valid[8], status[11:9], rts_high[12],
	// rx_count[21:13], tx_space[30:22], tx_pending[31]
	output logic      [OUT_TDATA_W-1:0] m_axis_tdata
);

	localparam int unsigned RAW = $clog2(RX_DEPTH);
	localparam int unsigned TAW = $clog2(TX_DEPTH);
	localparam int unsigned RSW = $clog2(RX_DEPTH + 1);
	localparam int unsigned TSW = $clog2(TX_DEPTH + 1);
	localparam int unsigned IW  = ((RAW > BYTE_W) ? RAW : BYTE_W) + 1;

	// input fields
	op_t               op;
	logic [BYTE_W-1:0] byte_in;
	logic [BYTE_W-1:0] peek_offset;
	logic              cts_high;

	assign op          = op_t'(s_axis_tdata[2:0]);
	assign byte_in     = s_axis_tdata[10:3];
	assign peek_offset = s_axis_tdata[18:11];
	assign cts_high    = s_axis_tdata[19];

	logic accept;
	logic out_valid_q;

	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign accept        = s_axis_tvalid && s_axis_tready;

	// configuration
	logic nonblocking_q, running_q;
	logic rx_size_we, tx_size_we;

	assign rx_size_we = cfg_we && (cfg_index == REG_RX_SIZE);
	assign tx_size_we = cfg_we && (cfg_index == REG_TX_SIZE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nonblocking_q <= 1'b0;
			running_q     <= 1'b0;
		end else if (cfg_we) begin
			if (cfg_index == REG_NONBLOCKING) begin
				nonblocking_q <= cfg_wdata[0];
			end
			if (cfg_index == REG_RUNNING) begin
				running_q <= cfg_wdata[0];
			end
		end
	end

	// rings
	ring_cmd_t  rx_cmd, tx_cmd;
	ring_flag_t rx_flags, tx_flags;
	logic [RAW-1:0] rx_head, rx_tail;
	logic [TAW-1:0] tx_head, tx_tail;
	logic [RSW-1:0] rx_size, rx_fill;
	logic [TSW-1:0] tx_size, tx_fill;

	ubqp_ring #(.DEPTH(RX_DEPTH)) u_rx_ring (
		.clk        (clk),
		.arst_n     (arst_n),
		.size_we    (rx_size_we),
		.size_wdata (cfg_wdata),
		.cmd        (rx_cmd),
		.head       (rx_head),
		.tail       (rx_tail),
		.flags      (rx_flags),
		.size       (rx_size),
		.fill       (rx_fill)
	);

	ubqp_ring #(.DEPTH(TX_DEPTH)) u_tx_ring (
		.clk        (clk),
		.arst_n     (arst_n),
		.size_we    (tx_size_we),
		.size_wdata (cfg_wdata),
		.cmd        (tx_cmd),
		.head       (tx_head),
		.tail       (tx_tail),
		.flags      (tx_flags),
		.size       (tx_size),
		.fill       (tx_fill)
	);

	// peek address: tail + offset wrapped once by the size
	logic [IW-1:0]  peek_sum, peek_wrap;
	logic           peek_bad;
	logic [RAW-1:0] peek_addr;

	assign peek_sum  = IW'(rx_tail) + IW'(peek_offset);
	assign peek_wrap = (peek_sum >= IW'(rx_size)) ? (peek_sum - IW'(rx_size)) : peek_sum;
	assign peek_addr = peek_wrap[RAW-1:0];
	assign peek_bad  = IW'(peek_offset) >= IW'(rx_size);

	// event decode
	status_t        status_d;
	logic           byte_valid_d;
	logic           sel_tx_d;
	logic           rx_re, tx_re;
	logic [RAW-1:0] rx_raddr;

	always_comb begin
		status_d     = ST_OK;
		byte_valid_d = 1'b0;
		sel_tx_d     = 1'b0;
		rx_cmd       = '0;
		tx_cmd       = '0;
		rx_re        = 1'b0;
		tx_re        = 1'b0;
		rx_raddr     = rx_tail;
		case (op)
			OP_LINE_IN, OP_UNGET: begin
				if (rx_flags.full) begin
					status_d = ST_DROPPED;
				end else begin
					rx_cmd.push = 1'b1;
				end
			end
			OP_TX_READY: begin
				sel_tx_d = 1'b1;
				if (tx_flags.empty) begin
					status_d = ST_EMPTY;
				end else if (cts_high) begin
					status_d = ST_RETRY;
				end else begin
					tx_cmd.pop   = 1'b1;
					tx_re        = 1'b1;
					byte_valid_d = 1'b1;
				end
			end
			OP_PUT: begin
				if (!running_q) begin
					status_d = ST_NOT_RUN;
				end else if (tx_flags.full) begin
					status_d = nonblocking_q ? ST_DROPPED : ST_RETRY;
				end else begin
					tx_cmd.push = 1'b1;
				end
			end
			OP_GET: begin
				if (!running_q) begin
					status_d = ST_NOT_RUN;
				end else if (rx_flags.empty) begin
					status_d = nonblocking_q ? ST_EMPTY : ST_RETRY;
				end else begin
					rx_cmd.pop   = 1'b1;
					rx_re        = 1'b1;
					byte_valid_d = 1'b1;
				end
			end
			OP_PEEK: begin
				rx_raddr = peek_addr;
				if (!running_q) begin
					status_d = ST_NOT_RUN;
				end else if (rx_flags.empty) begin
					status_d = ST_EMPTY;
				end else if (peek_bad) begin
					status_d = ST_BAD_OFFSET;
				end else begin
					rx_re        = 1'b1;
					byte_valid_d = 1'b1;
				end
			end
			default: begin
			end
		endcase
		if (!accept) begin
			rx_cmd = '0;
			tx_cmd = '0;
			rx_re  = 1'b0;
			tx_re  = 1'b0;
		end
	end

	// byte stores
	logic [BYTE_W-1:0] rx_rdata, tx_rdata;

	ubqp_ram #(.DEPTH(RX_DEPTH)) u_rx_ram (
		.clk   (clk),
		.we    (rx_cmd.push),
		.waddr (rx_head),
		.wdata (byte_in),
		.re    (rx_re),
		.raddr (rx_raddr),
		.rdata (rx_rdata)
	);

	ubqp_ram #(.DEPTH(TX_DEPTH)) u_tx_ram (
		.clk   (clk),
		.we    (tx_cmd.push),
		.waddr (tx_head),
		.wdata (byte_in),
		.re    (tx_re),
		.raddr (tx_tail),
		.rdata (tx_rdata)
	);

	// result stage; counts come from ring state, which holds until the next
	// transfer in or size write
	status_t status_s1;
	logic    byte_valid_s1, sel_tx_s1, cts_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1     <= status_d;
			byte_valid_s1 <= byte_valid_d;
			sel_tx_s1     <= sel_tx_d;
			cts_s1        <= cts_high;
		end
	end

	logic [BYTE_W-1:0]    byte_out;
	logic [TSW-1:0]       tx_free;
	logic                 rts_high;
	logic                 tx_pending;
	logic [CNT_OUT_W-1:0] rx_count_o, tx_space_o;

	assign byte_out   = !byte_valid_s1 ? '0 : (sel_tx_s1 ? tx_rdata : rx_rdata);
	assign tx_free    = tx_size - tx_fill;
	assign rts_high   = rx_fill > ((rx_size >> 1) + (rx_size >> 2));
	assign tx_pending = !tx_flags.empty && !cts_s1;
	assign rx_count_o = CNT_OUT_W'(rx_fill);
	assign tx_space_o = CNT_OUT_W'(tx_free);

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {tx_pending, tx_space_o, rx_count_o, rts_high,
		status_s1, byte_valid_s1, byte_out};

	// checks
	a_rx_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(rx_flags.full && rx_flags.empty))
		else $error("rx ring full and empty at once");

	a_tx_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		tx_fill <= tx_size)
		else $error("tx fill exceeds ring size");

	a_byte_needs_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && byte_valid_s1) |-> (status_s1 == ST_OK))
		else $error("byte reported with non-ok status");

	a_get_clears_full: assert property (@(posedge clk) disable iff (!arst_n)
		(rx_cmd.pop && !rx_size_we) |=> !rx_flags.full)
		else $error("rx ring still full after a get");

endmodule

`default_nettype wire

// ===== verif/uart_buffered_queue_pair_core_tb.sv =====
// ----------------------------------------------------------------------------
// uart_buffered_queue_pair_core_tb
// Self-checking bench for the serial receive/transmit ring pair.
// ----------------------------------------------------------------------------
// Events go in on s_axis and results come back on m_axis. A behavioral copy
// of both rings in the bench predicts every result at input transfer time.
// The checker compares each output transfer against the oldest prediction.
// Stimulus: directed corner cases first, then random traffic over many ring
// sizes and modes, then a long output stall that backs up the input. Both
// sides idle at random, except during one quiet random phase and the stall test.
// ----------------------------------------------------------------------------

module uart_buffered_queue_pair_core_tb import ubqp_pkg::*; ;
	timeunit 1ns;
	timeprecision 1ps;

	localparam realtime CLK_PERIOD   = 4.0;
	localparam int      RESET_CYCLES = 8;
	localparam int      IDLE_PCT     = 21;
	localparam int      LONG_HOLD    = 300;
	localparam int      MAX_REPORTS  = 10;
	localparam realtime TIMEOUT_NS   = 1_000_000.0;

	// operation codes the block does not use
	localparam logic [2:0] OP_SPARE6 = 3'd6;
	localparam logic [2:0] OP_SPARE7 = 3'd7;

	typedef struct packed {
		logic [2:0] op;
		logic [7:0] data;
		logic [7:0] offset;
		logic       cts_high;
	} serial_event_t;

	typedef struct packed {
		logic [7:0] byte_out;
		logic       byte_valid;
		logic [2:0] status;
		logic       rts_high;
		logic [8:0] rx_count;
		logic [8:0] tx_space;
		logic       tx_pending;
	} port_result_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_W-1:0]       cfg_wdata = '0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	// operation[2:0], byte_in[10:3], peek_offset[18:11], cts_high[19], zero
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	// byte_out[7:0], byte_valid[8], status[11:9], rts_high[12],
	// rx_count[21:13], tx_space[30:22], tx_pending[31]
	logic [OUT_TDATA_W-1:0] m_axis_tdata;

	uart_buffered_queue_pair_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	// ring model
	logic [7:0]  rx_mem [RX_DEPTH_DEF];
	logic [7:0]  tx_mem [TX_DEPTH_DEF];
	bit          rx_written [RX_DEPTH_DEF];
	int unsigned rx_wr, rx_rd, tx_wr, tx_rd, rx_len, tx_len;
	bit          rx_full, rx_empty, tx_full, tx_empty, nb_mode, port_on;

	port_result_t expected_results [$];
	int          err_count = 0;
	bit          quiet_mode = 1'b0;
	int          hold_req_id = 0;
	int          hold_ack_id = 0;
	int          hold_left = 0;

	initial begin
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("FAILURE");
		$finish;
	end

	function automatic int unsigned rx_level();
		if (rx_full) return rx_len;
		if (rx_wr >= rx_rd) return rx_wr - rx_rd;
		return rx_wr + rx_len - rx_rd;
	endfunction

	function automatic int unsigned tx_room();
		if (tx_empty) return tx_len;
		if (tx_rd >= tx_wr) return tx_rd - tx_wr;
		return tx_rd + tx_len - tx_wr;
	endfunction

	function automatic int unsigned bump(int unsigned p, int unsigned len);
		return (p + 1 >= len) ? 0 : p + 1;
	endfunction

	function automatic int unsigned clamp_len(logic [CFG_W-1:0] v, int unsigned depth);
		if (v == 0) return 1;
		if (v > depth) return depth;
		return v;
	endfunction

	function automatic void rx_insert(logic [7:0] b);
		rx_mem[rx_wr] = b;
		rx_written[rx_wr] = 1'b1;
		rx_empty = 1'b0;
		rx_wr = bump(rx_wr, rx_len);
		if (rx_wr == rx_rd) rx_full = 1'b1;
	endfunction

	function automatic void model_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] v);
		case (idx)
			REG_RX_SIZE: begin
				rx_len = clamp_len(v, RX_DEPTH_DEF);
				rx_wr = 0; rx_rd = 0; rx_full = 1'b0; rx_empty = 1'b1;
			end
			REG_TX_SIZE: begin
				tx_len = clamp_len(v, TX_DEPTH_DEF);
				tx_wr = 0; tx_rd = 0; tx_full = 1'b0; tx_empty = 1'b1;
			end
			REG_NONBLOCKING: nb_mode = v[0];
			REG_RUNNING:     port_on = v[0];
			default: ;
		endcase
	endfunction

	function automatic void model_reset();
		model_config(REG_RX_SIZE, CFG_W'(SIZE_RESET));
		model_config(REG_TX_SIZE, CFG_W'(SIZE_RESET));
		nb_mode = 1'b0;
		port_on = 1'b0;
	endfunction

	// advances the ring model by one event and returns what the port reports
	function automatic port_result_t predict_port(serial_event_t ev);
		port_result_t r;
		int unsigned  idx, lvl;
		r = '0;
		r.status = ST_OK;
		case (ev.op)
			OP_LINE_IN, OP_UNGET: begin
				if (rx_full) r.status = ST_DROPPED;
				else rx_insert(ev.data);
			end
			OP_TX_READY: begin
				if (tx_empty) r.status = ST_EMPTY;
				else if (ev.cts_high) r.status = ST_RETRY;
				else begin
					r.byte_out = tx_mem[tx_rd];
					r.byte_valid = 1'b1;
					tx_full = 1'b0;
					tx_rd = bump(tx_rd, tx_len);
					if (tx_wr == tx_rd) tx_empty = 1'b1;
				end
			end
			OP_PUT: begin
				if (!port_on) r.status = ST_NOT_RUN;
				else if (tx_full) r.status = nb_mode ? ST_DROPPED : ST_RETRY;
				else begin
					tx_mem[tx_wr] = ev.data;
					tx_empty = 1'b0;
					tx_wr = bump(tx_wr, tx_len);
					if (tx_wr == tx_rd) tx_full = 1'b1;
				end
			end
			OP_GET: begin
				if (!port_on) r.status = ST_NOT_RUN;
				else if (rx_empty) r.status = nb_mode ? ST_EMPTY : ST_RETRY;
				else begin
					r.byte_out = rx_mem[rx_rd];
					r.byte_valid = 1'b1;
					rx_full = 1'b0;
					rx_rd = bump(rx_rd, rx_len);
					if (rx_wr == rx_rd) rx_empty = 1'b1;
				end
			end
			OP_PEEK: begin
				if (!port_on) r.status = ST_NOT_RUN;
				else if (rx_empty) r.status = ST_EMPTY;
				else if (ev.offset >= rx_len) r.status = ST_BAD_OFFSET;
				else begin
					idx = (rx_rd + ev.offset) % rx_len;
					r.byte_out = rx_mem[idx];
					r.byte_valid = 1'b1;
				end
			end
			default: ;
		endcase
		lvl = rx_level();
		r.rts_high = (lvl > (rx_len >> 1) + (rx_len >> 2));
		r.rx_count = 9'(lvl);
		r.tx_space = 9'(tx_room());
		r.tx_pending = !tx_empty && !ev.cts_high;
		return r;
	endfunction

	function automatic serial_event_t mk_event(logic [2:0] op, logic [7:0] b,
			logic [7:0] off, logic cts);
		serial_event_t ev;
		ev.op = op;
		ev.data = b;
		ev.offset = off;
		ev.cts_high = cts;
		return ev;
	endfunction

	// drain_bias favors get and transmitter ready, otherwise the rings fill
	function automatic serial_event_t random_event(bit drain_bias);
		serial_event_t ev;
		int unsigned   pick, idx;
		pick = $urandom_range(99);
		if (!drain_bias) begin
			if (pick < 35)      ev.op = OP_LINE_IN;
			else if (pick < 58) ev.op = OP_PUT;
			else if (pick < 68) ev.op = OP_UNGET;
			else if (pick < 76) ev.op = OP_GET;
			else if (pick < 84) ev.op = OP_TX_READY;
			else if (pick < 97) ev.op = OP_PEEK;
			else                ev.op = $urandom_range(1) ? OP_SPARE6 : OP_SPARE7;
		end else begin
			if (pick < 14)      ev.op = OP_LINE_IN;
			else if (pick < 24) ev.op = OP_PUT;
			else if (pick < 29) ev.op = OP_UNGET;
			else if (pick < 58) ev.op = OP_GET;
			else if (pick < 84) ev.op = OP_TX_READY;
			else if (pick < 97) ev.op = OP_PEEK;
			else                ev.op = $urandom_range(1) ? OP_SPARE6 : OP_SPARE7;
		end
		ev.data = 8'($urandom);
		ev.offset = $urandom_range(1) ? 8'($urandom_range(rx_len)) : 8'($urandom);
		ev.cts_high = ($urandom_range(3) == 0);
		// keep a peek off store entries that were never filled
		if (ev.op == OP_PEEK && port_on && !rx_empty && ev.offset < rx_len) begin
			idx = (rx_rd + ev.offset) % rx_len;
			if (!rx_written[idx]) ev.offset = 8'($urandom_range(rx_level() - 1));
		end
		return ev;
	endfunction

	function automatic logic [CFG_W-1:0] random_size();
		case ($urandom_range(5))
			0:       return 9'($urandom);
			1:       return 9'($urandom_range(1, 3));
			2:       return 9'($urandom_range(4, 12));
			3:       return 9'($urandom_range(13, 64));
			default: return 9'($urandom_range(2, 8));
		endcase
	endfunction

	task automatic send_event(input serial_event_t ev);
		@(negedge clk);
		while (!quiet_mode && $urandom_range(99) < IDLE_PCT) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tdata  <= {{(IN_TDATA_W - 20){1'b0}}, ev.cts_high, ev.offset, ev.data, ev.op};
		s_axis_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		expected_results.push_back(predict_port(ev));
	endtask

	task automatic wait_for_results();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		model_config(idx, value);
	endtask

	task automatic set_config(input logic [CFG_W-1:0] rx_sz, input logic [CFG_W-1:0] tx_sz,
			input logic [CFG_W-1:0] nb, input logic [CFG_W-1:0] run);
		wait_for_results();
		write_reg(REG_RX_SIZE, rx_sz);
		write_reg(REG_TX_SIZE, tx_sz);
		write_reg(REG_NONBLOCKING, nb);
		write_reg(REG_RUNNING, run);
	endtask

	// straight after reset: port stopped, full-size rings
	task automatic test_port_stopped();
		send_event(mk_event(OP_PUT, 8'hA5, 8'h00, 1'b0));
		send_event(mk_event(OP_GET, 8'h00, 8'h00, 1'b0));
		send_event(mk_event(OP_PEEK, 8'h00, 8'h00, 1'b0));
		send_event(mk_event(OP_TX_READY, 8'h00, 8'h00, 1'b0));
		send_event(mk_event(OP_LINE_IN, 8'hFF, 8'h00, 1'b0));
		send_event(mk_event(OP_UNGET, 8'h00, 8'h00, 1'b1));
		send_event(mk_event(OP_SPARE6, 8'h00, 8'h00, 1'b0));
		send_event(mk_event(OP_SPARE7, 8'hFF, 8'hFF, 1'b1));
	endtask

	// blocking mode on tiny rings: full, empty, offsets, CTS hold
	task automatic test_small_rings();
		set_config(9'd4, 9'd2, 9'h000, 9'h1FF);
		send_event(mk_event(OP_PEEK, 8'h00, 8'h00, 1'b0));
		send_event(mk_event(OP_GET, 8'h00, 8'h00, 1'b0));
		send_event(mk_event(OP_LINE_IN, 8'h00, 8'h00, 1'b0));
		send_event(mk_event(OP_LINE_IN, 8'hFF, 8'h00, 1'b0));
		send_event(mk_event(OP_UNGET, 8'hC3, 8'h00, 1'b0));
		send_event(mk_event(OP_LINE_IN, 8'h5A, 8'h00, 1'b0));
		send_event(mk_event(OP_LINE_IN, 8'h11, 8'h00, 1'b0));
		send_event(mk_event(OP_PEEK, 8'h00, 8'h03, 1'b0));
		send_event(mk_event(OP_PEEK, 8'h00, 8'h04, 1'b0));
		send_event(mk_event(OP_GET, 8'h00, 8'h00, 1'b0));
		send_event(mk_event(OP_PUT, 8'h80, 8'h00, 1'b0));
		send_event(mk_event(OP_PUT, 8'h7F, 8'h00, 1'b0));
		send_event(mk_event(OP_PUT, 8'h01, 8'h00, 1'b0));
		send_event(mk_event(OP_TX_READY, 8'h00, 8'h00, 1'b1));
		send_event(mk_event(OP_TX_READY, 8'h00, 8'h00, 1'b0));
	endtask

	// nonblocking drop and empty answers; rx size written as zero
	task automatic test_nonblocking();
		wait_for_results();
		write_reg(REG_NONBLOCKING, 9'h001);
		write_reg(REG_RX_SIZE, 9'd0);
		send_event(mk_event(OP_PUT, 8'h33, 8'h00, 1'b0));
		send_event(mk_event(OP_PUT, 8'h44, 8'h00, 1'b0));
		send_event(mk_event(OP_GET, 8'h00, 8'h00, 1'b0));
		send_event(mk_event(OP_LINE_IN, 8'hEE, 8'h00, 1'b0));
		send_event(mk_event(OP_GET, 8'h00, 8'h00, 1'b0));
	endtask

	task automatic test_random_traffic();
		int unsigned run_len;
		bit          drain_bias;
		for (int phase = 0; phase < 9; phase++) begin
			case (phase)
				0: set_config(9'd256, 9'd1, 9'h000, 9'h001);
				1: set_config(9'd1, 9'd256, 9'h001, 9'h001);
				2: set_config(9'd0, 9'h1FF, 9'h1FE, 9'h1FF);
				default: set_config(random_size(), random_size(), 9'($urandom),
					{8'($urandom), ($urandom_range(3) != 0)});
			endcase
			quiet_mode = (phase == 4);
			drain_bias = 1'b0;
			run_len = 0;
			for (int n = 0; n < 52; n++) begin
				if (run_len == 0) begin
					drain_bias = ~drain_bias;
					run_len = $urandom_range(6, 20);
				end
				run_len--;
				if (phase == 6 && n == 26) wait_for_results();
				send_event(random_event(drain_bias));
			end
		end
		quiet_mode = 1'b0;
	endtask

	// receiver holds off long enough for the input to stall
	task automatic test_output_stall();
		set_config(9'd8, 9'd6, 9'h001, 9'h001);
		quiet_mode = 1'b1;
		hold_req_id++;
		for (int n = 0; n < 48; n++) send_event(random_event(n >= 24));
		wait_for_results();
		quiet_mode = 1'b0;
	endtask

	always @(negedge clk) begin
		if (hold_req_id != hold_ack_id) begin
			hold_ack_id = hold_req_id;
			hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= quiet_mode ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
		end
	end

	always @(posedge clk) begin
		port_result_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.byte_out   = m_axis_tdata[7:0];
			got.byte_valid = m_axis_tdata[8];
			got.status     = m_axis_tdata[11:9];
			got.rts_high   = m_axis_tdata[12];
			got.rx_count   = m_axis_tdata[21:13];
			got.tx_space   = m_axis_tdata[30:22];
			got.tx_pending = m_axis_tdata[31];
			if (expected_results.size() == 0) begin
				err_count++;
				if (err_count <= MAX_REPORTS)
					$display("%0t: result transfer with nothing predicted: %h", $realtime,
						m_axis_tdata);
			end else begin
				want = expected_results.pop_front();
				if (got.byte_out !== want.byte_out || got.byte_valid !== want.byte_valid ||
						got.status !== want.status || got.rts_high !== want.rts_high ||
						got.rx_count !== want.rx_count || got.tx_space !== want.tx_space ||
						got.tx_pending !== want.tx_pending) begin
					err_count++;
					if (err_count <= MAX_REPORTS) begin
						$write("%0t: mismatch byte/valid/status/rts/rx/txfree/pend",
							$realtime);
						$write(" want %h/%b/%0d/%b/%0d/%0d/%b",
							want.byte_out, want.byte_valid, want.status,
							want.rts_high, want.rx_count, want.tx_space, want.tx_pending);
						$display(" got %h/%b/%0d/%b/%0d/%0d/%b",
							got.byte_out, got.byte_valid, got.status, got.rts_high,
							got.rx_count, got.tx_space, got.tx_pending);
					end
				end
			end
		end
	end

	initial begin
		model_reset();
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_port_stopped();
		test_small_rings();
		test_nonblocking();
		test_random_traffic();
		test_output_stall();
		wait_for_results();
		repeat (4) @(posedge clk);
		if (err_count == 0 && expected_results.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

// ===== files.f =====
sv/ubqp_pkg.sv
sv/ubqp_ram.sv
sv/ubqp_ring.sv
sv/uart_buffered_queue_pair_core.sv
verif/uart_buffered_queue_pair_core_tb.sv
